/* sv/rgb_point_color_transform_core_defines.svh */
// Assertion macros shared by the color transform RTL.
`ifndef RGB_POINT_COLOR_TRANSFORM_CORE_DEFINES_SVH
`define RGB_POINT_COLOR_TRANSFORM_CORE_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted
`define RPCT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked while reset is asserted
`define RPCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/rpct_pkg.sv */
`default_nettype none

package rpct_pkg;

  localparam int CH_W   = 8;
  localparam int MODE_W = 2;

  // mode register codes
  localparam logic [MODE_W-1:0] MODE_GRAY  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SEPIA = 2'd1;
  localparam logic [MODE_W-1:0] MODE_NEG   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RESET = MODE_GRAY;

  localparam logic [CH_W-1:0] CH_MAX = 8'd255;

  // sepia coefficients, unsigned Q0.16
  localparam int COEF_W   = 16;
  localparam int COEF_FRAC = 16;
  localparam logic [COEF_W-1:0] SEP_RR = 16'd25756;
  localparam logic [COEF_W-1:0] SEP_RG = 16'd50397;
  localparam logic [COEF_W-1:0] SEP_RB = 16'd12386;
  localparam logic [COEF_W-1:0] SEP_GR = 16'd22872;
  localparam logic [COEF_W-1:0] SEP_GG = 16'd44958;
  localparam logic [COEF_W-1:0] SEP_GB = 16'd11010;
  localparam logic [COEF_W-1:0] SEP_BR = 16'd17826;
  localparam logic [COEF_W-1:0] SEP_BG = 16'd34996;
  localparam logic [COEF_W-1:0] SEP_BB = 16'd8585;

  // weighted sum width: largest row sum 88539 * 255 < 2^25
  localparam int SEP_SUM_W = 25;

  // divide by 3 as (s * 683) >> 11, exact for s <= 765
  localparam int GRAY_SUM_W  = 10;
  localparam int DIV3_MUL_W  = 10;
  localparam int DIV3_PROD_W = GRAY_SUM_W + DIV3_MUL_W;
  localparam int DIV3_SHIFT  = 11;
  localparam logic [DIV3_MUL_W-1:0] DIV3_MUL = 10'd683;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

endpackage

`default_nettype wire

/* sv/rgb_point_color_transform_core.sv */
// An accepted item passes through the input register and then the result register before out_valid.
// Throughput: one item per cycle; both stages advance together unless out_stall holds
// a valid result, and then the input register takes one more item only if it is empty.
// Reset (rst_n low, synchronous): both stages empty, mode returns to grayscale.
// cfg_ready is always high; the mode write takes effect on the next item processed.
`default_nettype none

module rgb_point_color_transform_core
  import rpct_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // configuration
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [MODE_W-1:0] cfg_data,
  // input items
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [CH_W-1:0]   in_red_in,
  input  wire logic [CH_W-1:0]   in_green_in,
  input  wire logic [CH_W-1:0]   in_blue_in,
  // result items
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [CH_W-1:0]        out_red_out,
  output logic [CH_W-1:0]        out_green_out,
  output logic [CH_W-1:0]        out_blue_out
);

  `include "rgb_point_color_transform_core_defines.svh"

  logic [MODE_W-1:0] mode_r;
  logic              s1_v_r;
  pixel_t            s1_pix_r;
  logic              s2_v_r;
  pixel_t            s2_pix_r;
  pixel_t            alu_pix;
  logic              s2_load;
  logic              s1_load;

  // mode register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_data;
    end
  end

  // stage advance: result register frees when empty or taken
  assign s2_load  = !s2_v_r || !out_stall;
  assign s1_load  = !s1_v_r || s2_load;
  assign in_stall = !s1_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_v_r <= in_valid;
      end
      if (s2_load) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_valid && s1_load) begin
      s1_pix_r <= '{red: in_red_in, green: in_green_in, blue: in_blue_in};
    end
  end

  rpct_color_alu u_alu (
    .mode    (mode_r),
    .pix_in  (s1_pix_r),
    .pix_out (alu_pix)
  );

  // result register
  always_ff @(posedge clk) begin
    if (s1_v_r && s2_load) begin
      s2_pix_r <= alu_pix;
    end
  end

  assign out_valid     = s2_v_r;
  assign out_red_out   = s2_pix_r.red;
  assign out_green_out = s2_pix_r.green;
  assign out_blue_out  = s2_pix_r.blue;

  `RPCT_ASSERT_NOW(a_stall_only_full, clk, rst_n, in_stall,
    s1_v_r && s2_v_r && out_stall, "input stalled while pipeline not blocked")
  `RPCT_ASSERT_NEXT(a_accept_fills, clk, rst_n, in_valid && !in_stall,
    s1_v_r, "accepted item not held in input register")
  `RPCT_ASSERT_NEXT(a_advance, clk, rst_n, s1_v_r && s2_load,
    out_valid, "item lost between stages")
  `RPCT_ASSERT_NEXT(a_neg_result, clk, rst_n, s1_v_r && s2_load && mode_r == MODE_NEG,
    out_red_out == ~$past(s1_pix_r.red), "negative red channel wrong")

endmodule

`default_nettype wire

/* sv/rpct_color_alu.sv */
`default_nettype none

module rpct_color_alu
  import rpct_pkg::*;
(
  input  wire logic [MODE_W-1:0] mode,
  input  wire pixel_t            pix_in,
  output pixel_t                 pix_out
);

  // one sepia channel: Q0.16 weighted sum, drop fraction, clamp at 255
  function automatic logic [CH_W-1:0] sepia_ch(
    input logic [COEF_W-1:0] c0,
    input logic [COEF_W-1:0] c1,
    input logic [COEF_W-1:0] c2,
    input pixel_t            p
  );
    logic [SEP_SUM_W-1:0] acc;
    acc = SEP_SUM_W'(c0) * SEP_SUM_W'(p.red)
        + SEP_SUM_W'(c1) * SEP_SUM_W'(p.green)
        + SEP_SUM_W'(c2) * SEP_SUM_W'(p.blue);
    if (|acc[SEP_SUM_W-1:COEF_FRAC+CH_W]) begin
      sepia_ch = CH_MAX;
    end else begin
      sepia_ch = acc[COEF_FRAC+CH_W-1:COEF_FRAC];
    end
  endfunction

  logic [GRAY_SUM_W-1:0]  gray_sum;
  logic [DIV3_PROD_W-1:0] gray_prod;
  logic [CH_W-1:0]        gray;
  pixel_t                 sepia;

  // truncated mean via reciprocal multiply
  assign gray_sum  = GRAY_SUM_W'(pix_in.red) + GRAY_SUM_W'(pix_in.green)
                   + GRAY_SUM_W'(pix_in.blue);
  assign gray_prod = DIV3_PROD_W'(gray_sum) * DIV3_PROD_W'(DIV3_MUL);
  assign gray      = gray_prod[DIV3_SHIFT+CH_W-1:DIV3_SHIFT];

  assign sepia.red   = sepia_ch(SEP_RR, SEP_RG, SEP_RB, pix_in);
  assign sepia.green = sepia_ch(SEP_GR, SEP_GG, SEP_GB, pix_in);
  assign sepia.blue  = sepia_ch(SEP_BR, SEP_BG, SEP_BB, pix_in);

  // operation select; unused code passes the pixel through
  always_comb begin
    case (mode)
      MODE_GRAY: begin
        pix_out = '{red: gray, green: gray, blue: gray};
      end
      MODE_SEPIA: begin
        pix_out = sepia;
      end
      MODE_NEG: begin
        pix_out = '{red: CH_MAX - pix_in.red, green: CH_MAX - pix_in.green,
                    blue: CH_MAX - pix_in.blue};
      end
      default: begin
        pix_out = pix_in;
      end
    endcase
  end

endmodule

`default_nettype wire
